// ===== hdl/dgll_pkg.sv =====
// Shared types, widths and codes for the diagonal Gaussian log-likelihood scorer.
// Used by every module of the block but dgll_ram; depends on nothing.
package dgll_pkg;

   localparam int CMD_W        = 3;
   localparam int ENTRY_W      = 8;
   localparam int DIM_W        = 6;
   localparam int VALUE_W      = 32;
   localparam int SAMPLE_W     = 16;
   localparam int CONST_W      = 32;
   localparam int SCORE_W      = 48;
   localparam int ENTRIES_W    = 9;
   localparam int DIMS_W       = 7;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 9;
   localparam int SQ_W         = 33;
   localparam int PROD_W       = 49;
   localparam int ACC_SHIFT    = 13;

   localparam int DEFAULT_MAX_ENTRIES = 256;
   localparam int DEFAULT_MAX_DIMS    = 64;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = 2;
   localparam int QUEUE_CNT_W  = 3;

   localparam logic [CMD_W-1:0] CMD_LOAD_FEATURE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_MEAN    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_INV_VAR = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LOAD_CONST   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SCORE        = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRIES_IN_USE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIMS_IN_USE    = 1'b1;

   localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 9'd256;
   localparam logic [DIMS_W-1:0]    DIMS_RESET    = 7'd64;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = 48'sh8000_0000_0000;

   typedef enum logic [2:0] {
      OP_FEATURE,
      OP_MEAN,
      OP_INV_VAR,
      OP_CONSTANT,
      OP_SCORE,
      OP_SCORE_ERROR
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [ENTRY_W-1:0]   entry_index;
      logic [DIM_W-1:0]     dim_index;
      logic [VALUE_W-1:0]   value;
   } queue_item_type;

endpackage

// ===== hdl/dgll_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for every store of the scorer.
module dgll_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/dgll_front.sv =====
// Front end: accepts commands, drops unknown or out-of-range ones, flags
// unscorable entries and queues the rest. Depends on dgll_pkg.
module dgll_front #(
   parameter int MAX_ENTRIES = dgll_pkg::DEFAULT_MAX_ENTRIES,
   parameter int MAX_DIMS    = dgll_pkg::DEFAULT_MAX_DIMS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [dgll_pkg::CMD_W-1:0]         req_cmd,
   input  logic [dgll_pkg::ENTRY_W-1:0]       req_entry_index,
   input  logic [dgll_pkg::DIM_W-1:0]         req_dim_index,
   input  logic [dgll_pkg::VALUE_W-1:0]       req_value,
   input  logic [dgll_pkg::ENTRIES_W-1:0]     entries_in_use,
   output logic                               q_valid,
   output dgll_pkg::queue_item_type           q_item,
   input  logic                               q_pop
);

   dgll_pkg::queue_item_type              q_mem_ff [dgll_pkg::QUEUE_DEPTH];
   logic [dgll_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [dgll_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [dgll_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;
   dgll_pkg::queue_item_type              push_item;
   logic                                  keep;
   logic                                  push;
   logic                                  entry_ok;
   logic                                  dim_ok;

   always_comb begin
      entry_ok = (32'(req_entry_index) < MAX_ENTRIES);
      dim_ok   = (32'(req_dim_index) < MAX_DIMS);
      push_item.entry_index = req_entry_index;
      push_item.dim_index   = req_dim_index;
      push_item.value       = req_value;
      push_item.op          = dgll_pkg::OP_FEATURE;
      keep                  = 1'b0;
      unique case (req_cmd)
         dgll_pkg::CMD_LOAD_FEATURE: begin
            push_item.op = dgll_pkg::OP_FEATURE;
            keep         = dim_ok;
         end
         dgll_pkg::CMD_LOAD_MEAN: begin
            push_item.op = dgll_pkg::OP_MEAN;
            keep         = entry_ok && dim_ok;
         end
         dgll_pkg::CMD_LOAD_INV_VAR: begin
            push_item.op = dgll_pkg::OP_INV_VAR;
            keep         = entry_ok && dim_ok;
         end
         dgll_pkg::CMD_LOAD_CONST: begin
            push_item.op = dgll_pkg::OP_CONSTANT;
            keep         = entry_ok;
         end
         dgll_pkg::CMD_SCORE: begin
            keep = 1'b1;
            if (entry_ok && (dgll_pkg::ENTRIES_W'(req_entry_index) < entries_in_use)) begin
               push_item.op = dgll_pkg::OP_SCORE;
            end else begin
               push_item.op = dgll_pkg::OP_SCORE_ERROR;
            end
         end
         default: begin
            keep = 1'b0;
         end
      endcase

      push      = start && !busy && keep;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + dgll_pkg::QUEUE_CNT_W'(push) - dgll_pkg::QUEUE_CNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign busy    = (count_ff == dgll_pkg::QUEUE_CNT_W'(dgll_pkg::QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = q_mem_ff[rd_ptr_ff];

endmodule

// ===== hdl/dgll_back.sv =====
// Back end: performs queued loads into the stores and scores entries with a
// pipelined multiply-accumulate over the dimensions. Depends on dgll_pkg, dgll_ram.
module dgll_back #(
   parameter int MAX_ENTRIES = dgll_pkg::DEFAULT_MAX_ENTRIES,
   parameter int MAX_DIMS    = dgll_pkg::DEFAULT_MAX_DIMS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [dgll_pkg::DIMS_W-1:0]         dims_in_use,
   input  logic                                q_valid,
   input  dgll_pkg::queue_item_type            q_item,
   output logic                                q_pop,
   output logic                                rsp_valid,
   output logic [dgll_pkg::ENTRY_W-1:0]        rsp_scored_entry,
   output logic [dgll_pkg::SCORE_W-1:0]        rsp_score,
   output logic                                rsp_status
);

   localparam int EA     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int DA     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int STORE  = MAX_ENTRIES * MAX_DIMS;
   localparam int MA     = (STORE > 1) ? $clog2(STORE) : 1;
   localparam int DCW    = $clog2(MAX_DIMS + 1);
   localparam int ACC_W  = dgll_pkg::PROD_W + DCW;
   localparam int SUM_W  = ACC_W - dgll_pkg::ACC_SHIFT + 2;
   localparam int NEG_W  = (SUM_W + 1 > dgll_pkg::SCORE_W + 1) ? SUM_W + 1
                                                              : dgll_pkg::SCORE_W + 1;
   localparam logic signed [NEG_W-1:0] SAT_HI = NEG_W'(dgll_pkg::SCORE_MAX);
   localparam logic signed [NEG_W-1:0] SAT_LO = NEG_W'(dgll_pkg::SCORE_MIN);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_SUM,
      ST_SAT
   } state_type;

   state_type                           state_ff, state_in;
   logic [DCW-1:0]                      j_ff, j_in;
   logic [DCW-1:0]                      nd_ff, nd_in;
   logic [DCW-1:0]                      nd_cfg;
   logic [dgll_pkg::ENTRY_W-1:0]        entry_ff, entry_in;
   logic [MA-1:0]                       base_ff, base_in;
   logic                                rd_valid_ff, rd_valid_in;
   logic                                sq_valid_ff;
   logic                                prod_valid_ff;
   logic [dgll_pkg::SQ_W-1:0]           sq_ff, sq_in;
   logic [dgll_pkg::SAMPLE_W-1:0]       iv_ff;
   logic [dgll_pkg::PROD_W-1:0]         prod_ff, prod_in;
   logic [ACC_W-1:0]                    acc_ff, acc_in;
   logic signed [SUM_W-1:0]             sum_ff, sum_in;
   logic signed [NEG_W-1:0]             neg;
   logic signed [NEG_W-1:0]             sat;
   logic signed [dgll_pkg::SAMPLE_W:0]  diff;
   logic signed [2*dgll_pkg::SAMPLE_W+1:0] sq_full;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [dgll_pkg::ENTRY_W-1:0]        rsp_entry_ff, rsp_entry_in;
   logic [dgll_pkg::SCORE_W-1:0]        rsp_score_ff, rsp_score_in;
   logic                                rsp_status_ff, rsp_status_in;

   logic [dgll_pkg::SAMPLE_W-1:0]       feat_rd, mean_rd, iv_rd;
   logic [dgll_pkg::CONST_W-1:0]        const_rd;
   logic                                feat_we, mean_we, iv_we, const_we;
   logic [MA-1:0]                       load_addr;
   logic [MA-1:0]                       mean_ra;

   assign nd_cfg    = (32'(dims_in_use) > MAX_DIMS) ? DCW'(MAX_DIMS) : DCW'(dims_in_use);
   assign load_addr = MA'(32'(q_item.entry_index) * MAX_DIMS + 32'(q_item.dim_index));
   assign mean_ra   = base_ff + MA'(j_ff);
   assign feat_we   = q_pop && (q_item.op == dgll_pkg::OP_FEATURE);
   assign mean_we   = q_pop && (q_item.op == dgll_pkg::OP_MEAN);
   assign iv_we     = q_pop && (q_item.op == dgll_pkg::OP_INV_VAR);
   assign const_we  = q_pop && (q_item.op == dgll_pkg::OP_CONSTANT);

   dgll_ram #(.WIDTH(dgll_pkg::SAMPLE_W), .DEPTH(MAX_DIMS)) u_feature_ram (
      .clock   (clock),
      .wr_en   (feat_we),
      .wr_addr (DA'(q_item.dim_index)),
      .wr_data (q_item.value[dgll_pkg::SAMPLE_W-1:0]),
      .rd_addr (DA'(j_ff)),
      .rd_data (feat_rd)
   );

   dgll_ram #(.WIDTH(dgll_pkg::SAMPLE_W), .DEPTH(STORE)) u_mean_ram (
      .clock   (clock),
      .wr_en   (mean_we),
      .wr_addr (load_addr),
      .wr_data (q_item.value[dgll_pkg::SAMPLE_W-1:0]),
      .rd_addr (mean_ra),
      .rd_data (mean_rd)
   );

   dgll_ram #(.WIDTH(dgll_pkg::SAMPLE_W), .DEPTH(STORE)) u_inv_var_ram (
      .clock   (clock),
      .wr_en   (iv_we),
      .wr_addr (load_addr),
      .wr_data (q_item.value[dgll_pkg::SAMPLE_W-1:0]),
      .rd_addr (mean_ra),
      .rd_data (iv_rd)
   );

   dgll_ram #(.WIDTH(dgll_pkg::CONST_W), .DEPTH(MAX_ENTRIES)) u_constant_ram (
      .clock   (clock),
      .wr_en   (const_we),
      .wr_addr (EA'(q_item.entry_index)),
      .wr_data (q_item.value),
      .rd_addr (EA'(entry_ff)),
      .rd_data (const_rd)
   );

   always_comb begin
      diff    = $signed({feat_rd[dgll_pkg::SAMPLE_W-1], feat_rd})
              - $signed({mean_rd[dgll_pkg::SAMPLE_W-1], mean_rd});
      sq_full = diff * diff;
      sq_in   = sq_full[dgll_pkg::SQ_W-1:0];
      prod_in = dgll_pkg::PROD_W'(sq_ff) * dgll_pkg::PROD_W'(iv_ff);
      neg     = -NEG_W'(sum_ff);
      if (neg > SAT_HI) begin
         sat = SAT_HI;
      end else if (neg < SAT_LO) begin
         sat = SAT_LO;
      end else begin
         sat = neg;
      end
   end

   always_comb begin
      state_in      = state_ff;
      j_in          = j_ff;
      nd_in         = nd_ff;
      entry_in      = entry_ff;
      base_in       = base_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = 1'b0;
      rsp_entry_in  = rsp_entry_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_status_in = rsp_status_ff;
      q_pop         = 1'b0;
      rd_valid_in   = (state_ff == ST_ISSUE);
      acc_in        = prod_valid_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.op == dgll_pkg::OP_SCORE) begin
                  entry_in = q_item.entry_index;
                  base_in  = MA'(32'(q_item.entry_index) * MAX_DIMS);
                  nd_in    = nd_cfg;
                  j_in     = '0;
                  acc_in   = '0;
                  state_in = (nd_cfg == '0) ? ST_DRAIN : ST_ISSUE;
               end else if (q_item.op == dgll_pkg::OP_SCORE_ERROR) begin
                  rsp_valid_in  = 1'b1;
                  rsp_entry_in  = q_item.entry_index;
                  rsp_score_in  = '0;
                  rsp_status_in = 1'b1;
               end
            end
         end
         ST_ISSUE: begin
            if (j_ff == nd_ff - DCW'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + DCW'(1);
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !sq_valid_ff && !prod_valid_ff) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in = $signed({{(SUM_W - dgll_pkg::CONST_W){const_rd[dgll_pkg::CONST_W-1]}},
                              const_rd})
                   + $signed({2'b00, acc_ff[ACC_W-1:dgll_pkg::ACC_SHIFT]});
            state_in = ST_SAT;
         end
         ST_SAT: begin
            rsp_valid_in  = 1'b1;
            rsp_entry_in  = entry_ff;
            rsp_score_in  = sat[dgll_pkg::SCORE_W-1:0];
            rsp_status_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_valid_ff   <= 1'b0;
         sq_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= rd_valid_in;
         sq_valid_ff   <= rd_valid_ff;
         prod_valid_ff <= sq_valid_ff;
         rsp_valid_ff  <= rsp_valid_in;
      end
      j_ff          <= j_in;
      nd_ff         <= nd_in;
      entry_ff      <= entry_in;
      base_ff       <= base_in;
      sq_ff         <= sq_in;
      iv_ff         <= iv_rd;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      sum_ff        <= sum_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scored_entry = rsp_entry_ff;
   assign rsp_score        = rsp_score_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ===== hdl/diag_gaussian_log_likelihood.sv =====
// Channel      Handshake                   Payload
// command      start / busy                req_cmd, req_entry_index, req_dim_index, req_value
// result       rsp_valid (one-cycle pulse) rsp_scored_entry, rsp_score, rsp_status
// config       csr_write_enable            csr_index, csr_write_data
//
// Top level of the diagonal Gaussian scorer: holds the configuration registers and
// joins the front end, its four-deep transaction queue and the back end.
// Depends on dgll_pkg, dgll_front, dgll_back and dgll_ram.
//
// A load or an unscorable entry is finished as it is taken from the queue. A score holds
// the back end while it is taken from the queue, read once per dimension (dims_in_use,
// capped at MAX_DIMS), drained through the multiply-accumulate pipeline, added to the
// constant and saturated; with no dimension summed there are no reads. Each result is
// pulsed in the cycle after the back end finishes with it.
// Synchronous reset empties the queue and idles the back end; store contents are kept.
// busy rises while the queue is full; results are pulsed and cannot be stalled.
module diag_gaussian_log_likelihood #(
   parameter int MAX_ENTRIES = dgll_pkg::DEFAULT_MAX_ENTRIES,
   parameter int MAX_DIMS    = dgll_pkg::DEFAULT_MAX_DIMS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [dgll_pkg::CMD_W-1:0]          req_cmd,
   input  logic [dgll_pkg::ENTRY_W-1:0]        req_entry_index,
   input  logic [dgll_pkg::DIM_W-1:0]          req_dim_index,
   input  logic signed [dgll_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   output logic [dgll_pkg::ENTRY_W-1:0]        rsp_scored_entry,
   output logic signed [dgll_pkg::SCORE_W-1:0] rsp_score,
   output logic                                rsp_status,
   input  logic                                csr_write_enable,
   input  logic [dgll_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dgll_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   logic [dgll_pkg::ENTRIES_W-1:0] entries_in_use_ff, entries_in_use_in;
   logic [dgll_pkg::DIMS_W-1:0]    dims_in_use_ff, dims_in_use_in;
   logic                           q_valid;
   logic                           q_pop;
   dgll_pkg::queue_item_type       q_item;
   logic [dgll_pkg::SCORE_W-1:0]   score_bits;

   always_comb begin
      entries_in_use_in = entries_in_use_ff;
      dims_in_use_in    = dims_in_use_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            dgll_pkg::CSR_ENTRIES_IN_USE: begin
               entries_in_use_in = csr_write_data[dgll_pkg::ENTRIES_W-1:0];
            end
            dgll_pkg::CSR_DIMS_IN_USE: begin
               dims_in_use_in = csr_write_data[dgll_pkg::DIMS_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_in_use_ff <= dgll_pkg::ENTRIES_RESET;
         dims_in_use_ff    <= dgll_pkg::DIMS_RESET;
      end else begin
         entries_in_use_ff <= entries_in_use_in;
         dims_in_use_ff    <= dims_in_use_in;
      end
   end

   dgll_front #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_DIMS(MAX_DIMS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_entry_index (req_entry_index),
      .req_dim_index   (req_dim_index),
      .req_value       (req_value),
      .entries_in_use  (entries_in_use_ff),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   dgll_back #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_DIMS(MAX_DIMS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .dims_in_use      (dims_in_use_ff),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_scored_entry (rsp_scored_entry),
      .rsp_score        (score_bits),
      .rsp_status       (rsp_status)
   );

   assign rsp_score = $signed(score_bits);

endmodule

// ===== hdl/dgll_checker.sv =====
// Port-level checks for the diagonal Gaussian scorer, bound to its top level.
// Depends on dgll_pkg and diag_gaussian_log_likelihood.
module dgll_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic [dgll_pkg::SCORE_W-1:0]       rsp_score,
   input logic                               rsp_status
);

   // Reset leaves the queue empty and no result pending.
   a_reset_clears : assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("busy or rsp_valid high after reset");

   // A rejected score always reports zero.
   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_score == '0))
      else $error("error status with non-zero score");

   // A computed score leaves the back end through its final stages, so no
   // other transaction can be reported in the cycle just before it.
   a_ok_isolated : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_status) |-> !$past(rsp_valid))
      else $error("computed score directly follows another result");

endmodule

bind diag_gaussian_log_likelihood dgll_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_score  (rsp_score),
   .rsp_status (rsp_status)
);
